@@ hw/rtl/byte_ring_buffer_unit_macros.svh @@
// assertion macros used by byte_ring_buffer_unit.sv
`ifndef BYTE_RING_BUFFER_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BRB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/brb_pkg.sv @@
package brb_pkg;

	// width of the count and distance fields
	localparam int FIELD_W = 13;
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [FIELD_W-1:0] BUFFER_SIZE_RESET = 13'd4096;

	// register index taken from the word address
	typedef enum logic [0:0] {
		REG_BUFFER_SIZE = 1'b0
	} reg_idx_t;

	// operation codes
	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE     = 3'd0,
		KIND_OVERWRITE = 3'd1,
		KIND_READ      = 3'd2,
		KIND_PEEK      = 3'd3,
		KIND_SKIP      = 3'd4,
		KIND_CLEAR     = 3'd5
	} kind_t;

	// one result item
	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic [FIELD_W-1:0] amount_done;
		logic [FIELD_W-1:0] fill_level;
		logic               is_empty;
		logic               is_full;
	} res_t;

endpackage

@@ hw/rtl/byte_ring_buffer_unit.sv @@
// byte fifo: write, overwrite, read, peek, skip and clear, one result per item
// throughput: one item per cycle while out_ready keeps the output moving; all offset
// and count updates finish in the accept cycle; each result passes the byte store read
// port, whose data is registered, and then the output register before it is valid
// reset: offsets and fill count cleared, buffer_size set to 4096; the byte store
// itself is not cleared, only entries already written are ever read
`include "byte_ring_buffer_unit_macros.svh"

module byte_ring_buffer_unit #(
	parameter int DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [brb_pkg::PADDR_W-1:0]    paddr,
	input  logic [brb_pkg::PDATA_W-1:0]    pwdata,
	output logic [brb_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	// input items
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [brb_pkg::KIND_W-1:0]     kind,
	input  logic [brb_pkg::BYTE_W-1:0]     data_byte,
	input  logic [brb_pkg::FIELD_W-1:0]    peek_distance,
	input  logic [brb_pkg::FIELD_W-1:0]    skip_count,
	// result items
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [brb_pkg::BYTE_W-1:0]     out_byte,
	output logic [brb_pkg::FIELD_W-1:0]    amount_done,
	output logic [brb_pkg::FIELD_W-1:0]    fill_level,
	output logic                           is_empty,
	output logic                           is_full
);
	import brb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

	// offset plus count, wrapped once at the size in use
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] off,
		input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] size);
		logic [SW-1:0] s;
		s = SW'(off) + SW'(n);
		if (s >= SW'(size)) begin
			s = s - SW'(size);
		end
		return AW'(s);
	endfunction

	logic [FIELD_W-1:0] buffer_size_q;
	logic [AW-1:0]      rd_q;
	logic [AW-1:0]      wr_q;
	logic [FIELD_W-1:0] held_q;

	logic [BYTE_W-1:0]  byte_store [DEPTH];
	logic [BYTE_W-1:0]  rdata_s1;
	logic               valid_s1;
	logic               byte_sel_s1;
	res_t               res_s1;
	res_t               res_out;
	logic               out_v_q;
	res_t               out_res_q;

	logic               cfg_wr;
	logic               accept;
	logic               adv;
	logic [FIELD_W-1:0] size_use;
	logic [FIELD_W-1:0] dist_eff;
	logic [FIELD_W-1:0] cnt_eff;
	logic [AW-1:0]      rd_nx;
	logic [AW-1:0]      wr_nx;
	logic [FIELD_W-1:0] held_nx;
	logic [FIELD_W-1:0] done_nx;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      raddr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (reg_idx_t'(paddr[2]) == REG_BUFFER_SIZE);

	always_comb begin
		prdata = '0;
		if (reg_idx_t'(paddr[2]) == REG_BUFFER_SIZE) begin
			prdata = PDATA_W'(buffer_size_q);
		end
	end

	// handshake and pipeline advance
	assign adv      = valid_s1 && (!out_v_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	// size in use, capped at the store depth
	assign size_use = (32'(buffer_size_q) > DEPTH) ? FIELD_W'(DEPTH) : buffer_size_q;

	// operand clamps for peek and skip
	assign dist_eff = (peek_distance > held_q) ? '0 : peek_distance;
	assign cnt_eff  = (skip_count > held_q) ? held_q : skip_count;

	// next state and store access for one item
	always_comb begin
		rd_nx   = rd_q;
		wr_nx   = wr_q;
		held_nx = held_q;
		done_nx = '0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		raddr   = rd_q;
		if (size_use != '0) begin
			case (kind_t'(kind))
				KIND_WRITE: begin
					if (held_q < size_use) begin
						mem_we  = 1'b1;
						wr_nx   = wrap_add(wr_q, FIELD_W'(1), size_use);
						held_nx = held_q + FIELD_W'(1);
						done_nx = FIELD_W'(1);
					end
				end
				KIND_OVERWRITE: begin
					mem_we = 1'b1;
					wr_nx  = wrap_add(wr_q, FIELD_W'(1), size_use);
					if (held_q >= size_use) begin
						rd_nx   = wrap_add(rd_q, FIELD_W'(1), size_use);
						done_nx = FIELD_W'(1);
					end else begin
						held_nx = held_q + FIELD_W'(1);
					end
				end
				KIND_READ: begin
					if (held_q != '0) begin
						mem_re  = 1'b1;
						rd_nx   = wrap_add(rd_q, FIELD_W'(1), size_use);
						held_nx = held_q - FIELD_W'(1);
						done_nx = FIELD_W'(1);
					end
				end
				KIND_PEEK: begin
					if (dist_eff < held_q) begin
						mem_re  = 1'b1;
						raddr   = wrap_add(rd_q, dist_eff, size_use);
						done_nx = FIELD_W'(1);
					end
				end
				KIND_SKIP: begin
					rd_nx   = wrap_add(rd_q, cnt_eff, size_use);
					held_nx = held_q - cnt_eff;
					done_nx = cnt_eff;
				end
				KIND_CLEAR: begin
					rd_nx   = '0;
					wr_nx   = '0;
					held_nx = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// byte store, write port and registered read port
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			byte_store[wr_q] <= data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mem_re) begin
			rdata_s1 <= byte_store[raddr];
		end
	end

	// offsets, fill count and size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= BUFFER_SIZE_RESET;
			rd_q          <= '0;
			wr_q          <= '0;
			held_q        <= '0;
		end else if (cfg_wr) begin
			buffer_size_q <= pwdata[FIELD_W-1:0];
			rd_q          <= '0;
			wr_q          <= '0;
			held_q        <= '0;
		end else if (accept) begin
			rd_q   <= rd_nx;
			wr_q   <= wr_nx;
			held_q <= held_nx;
		end
	end

	// stage one: result waits for the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_sel_s1        <= mem_re;
			res_s1.out_byte    <= '0;
			res_s1.amount_done <= done_nx;
			res_s1.fill_level  <= held_nx;
			res_s1.is_empty    <= (held_nx == '0);
			res_s1.is_full     <= (held_nx == size_use);
		end
	end

	// result with the byte from the store read merged in
	always_comb begin
		res_out          = res_s1;
		res_out.out_byte = byte_sel_s1 ? rdata_s1 : '0;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_res_q <= res_out;
		end
	end

	assign out_valid   = out_v_q;
	assign out_byte    = out_res_q.out_byte;
	assign amount_done = out_res_q.amount_done;
	assign fill_level  = out_res_q.fill_level;
	assign is_empty    = out_res_q.is_empty;
	assign is_full     = out_res_q.is_full;

	// checks
	`BRB_ASSERT_NOW(a_held_in_range, 1'b1, held_q <= size_use, "fill count above size in use")
	`BRB_ASSERT_NOW(a_offsets_match, (held_q == '0) || (held_q == size_use), rd_q == wr_q, "offsets disagree with fill count")
	`BRB_ASSERT_NOW(a_offsets_bound, size_use != '0, (rd_q < size_use) && (wr_q < size_use), "offset beyond size in use")
	`BRB_ASSERT_NEXT(a_write_grows, accept && !cfg_wr && (kind_t'(kind) == KIND_WRITE) && (held_q < size_use), held_q == $past(held_q) + FIELD_W'(1), "write did not add a byte")
	`BRB_ASSERT_NOW(a_no_lost_result, valid_s1 && out_v_q && !out_ready, !in_ready, "item taken with full pipeline")

endmodule
